/* src/ssel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssel_pkg
// Shared types and constants of the still frame selector.
// ----------------------------------------------------------------------------
package ssel_pkg;

  localparam int PIX_W            = 8;
  localparam int SCORE_W          = 29;
  localparam int INDEX_W          = 24;
  localparam int MAX_FRAME_PIXELS = 2097152;
  localparam int ADDR_W           = $clog2(MAX_FRAME_PIXELS);
  localparam int POS_W            = ADDR_W + 1;
  localparam int MAX_WINDOW       = 15;
  localparam int WLEN_W           = 4;
  localparam int RING_W           = 4;
  localparam int Q_DEPTH          = 4;
  localparam int Q_AW             = 2;
  localparam int Q_CW             = 3;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
  } ssel_score_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
  } ssel_q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREAD,
    ST_CLATCH,
    ST_READ,
    ST_CMP,
    ST_DONE
  } ssel_state_t;

endpackage
`default_nettype wire

/* src/ssel_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssel_front
// Pixel intake: previous frame store and sum of absolute differences.
// ----------------------------------------------------------------------------
module ssel_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [ssel_pkg::PIX_W-1:0]   pixel,
  input  wire logic                         last_in_frame,
  input  wire ssel_pkg::ssel_q_status_t     q_status,
  output ssel_pkg::ssel_score_t             score_push
);
  import ssel_pkg::*;

  logic [PIX_W-1:0]   prev_mem [MAX_FRAME_PIXELS];
  logic [PIX_W-1:0]   rd_pix;
  logic [POS_W-1:0]   pos;
  logic               previous_valid;
  logic [SCORE_W-1:0] sum;
  logic               s1_valid;
  logic               s1_last;
  logic               s1_cmp;
  logic               s1_first;
  logic [PIX_W-1:0]   s1_pix;

  logic               accept;
  logic               in_range;
  logic [Q_CW:0]      occupancy;
  logic [PIX_W-1:0]   diff;
  logic [SCORE_W:0]   sum_add;
  logic [SCORE_W-1:0] sum_sat;

  // A frame end still in the pipeline already owns a queue slot.
  assign occupancy = {1'b0, q_status.count} + {{Q_CW{1'b0}}, s1_valid & s1_last};
  assign s_tready  = occupancy < (Q_CW+1)'(Q_DEPTH);
  assign accept    = s_tvalid & s_tready;
  assign in_range  = pos < POS_W'(MAX_FRAME_PIXELS);

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_pix <= prev_mem[pos[ADDR_W-1:0]];
      prev_mem[pos[ADDR_W-1:0]] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      previous_valid <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_in_frame) begin
          pos            <= '0;
          previous_valid <= 1'b1;
        end else if (in_range) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_last  <= last_in_frame;
      s1_cmp   <= previous_valid & in_range;
      s1_first <= ~previous_valid;
    end
  end

  assign diff    = (rd_pix > s1_pix) ? (rd_pix - s1_pix) : (s1_pix - rd_pix);
  assign sum_add = {1'b0, sum} + (s1_cmp ? (SCORE_W+1)'(diff) : '0);
  assign sum_sat = sum_add[SCORE_W] ? SCORE_MAX : sum_add[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (s1_valid) begin
      sum <= s1_last ? '0 : sum_sat;
    end
  end

  assign score_push.valid = s1_valid & s1_last;
  assign score_push.score = s1_first ? SCORE_MAX : sum_sat;

endmodule
`default_nettype wire

/* src/ssel_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssel_fifo
// Short queue of frame scores between the pixel front and the window back.
// ----------------------------------------------------------------------------
module ssel_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ssel_pkg::ssel_score_t    push,
  input  wire logic                     pop,
  output ssel_pkg::ssel_score_t         head,
  output ssel_pkg::ssel_q_status_t      status
);
  import ssel_pkg::*;

  logic [SCORE_W-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0]    wptr;
  logic [Q_AW-1:0]    rptr;
  logic [Q_CW-1:0]    count;
  logic               do_pop;

  assign do_pop = pop & (count != '0);

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wptr] <= push.score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + Q_AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + Q_AW'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head.valid   = count != '0;
  assign head.score   = mem[rptr];
  assign status.count = count;

endmodule
`default_nettype wire

/* src/ssel_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssel_back
// Score window: ring of recent frames, local minimum check, result register.
// ----------------------------------------------------------------------------
module ssel_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssel_pkg::ssel_score_t         q_head,
  output logic                               q_pop,
  input  wire logic [ssel_pkg::SCORE_W-1:0]  threshold_sum,
  input  wire logic [ssel_pkg::WLEN_W-1:0]   window_length,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ssel_pkg::INDEX_W-1:0]       frame_index,
  output logic [ssel_pkg::SCORE_W-1:0]       frame_score
);
  import ssel_pkg::*;

  logic [SCORE_W-1:0] ring_score [2**RING_W];
  logic [INDEX_W-1:0] ring_index [2**RING_W];
  logic [SCORE_W-1:0] rd_score;
  logic [INDEX_W-1:0] rd_index;

  ssel_state_t        state;
  ssel_state_t        state_next;
  logic [RING_W-1:0]  head;
  logic [WLEN_W-1:0]  fill;
  logic [INDEX_W-1:0] frame_counter;
  logic [WLEN_W-1:0]  len;
  logic [WLEN_W-1:0]  idx;
  logic [SCORE_W-1:0] centre_score;
  logic [INDEX_W-1:0] centre_index;
  logic               is_min;

  logic [WLEN_W-1:0]  len_now;
  logic [WLEN_W-1:0]  fill_after;
  logic [RING_W-1:0]  centre;
  logic [RING_W-1:0]  raddr;
  logic               ring_we;
  logic               do_latch;
  logic               do_fail;
  logic               do_inc;
  logic               emit;
  logic               load_out;
  logic               do_drop;
  logic [WLEN_W-1:0]  drop_cnt;

  assign len_now    = (window_length == '0) ? WLEN_W'(1) : window_length;
  assign fill_after = (fill == WLEN_W'(MAX_WINDOW)) ? fill : fill + WLEN_W'(1);
  assign centre     = RING_W'(len >> 1);
  assign emit       = is_min & (centre_score < threshold_sum);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_head.valid && fill_after >= len_now) begin
          state_next = ST_CREAD;
        end
      end
      ST_CREAD:  state_next = ST_CLATCH;
      ST_CLATCH: state_next = ST_READ;
      ST_READ:   state_next = ST_CMP;
      ST_CMP: begin
        if (centre_score > rd_score || idx == len - WLEN_W'(1)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (!(emit && m_tvalid && !m_tready)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    ring_we  = 1'b0;
    raddr    = head;
    do_latch = 1'b0;
    do_fail  = 1'b0;
    do_inc   = 1'b0;
    load_out = 1'b0;
    do_drop  = 1'b0;
    drop_cnt = WLEN_W'(1);
    unique case (state)
      ST_IDLE: begin
        q_pop   = q_head.valid;
        ring_we = q_head.valid;
      end
      ST_CREAD:  raddr = head + centre;
      ST_CLATCH: do_latch = 1'b1;
      ST_READ:   raddr = head + RING_W'(idx);
      ST_CMP: begin
        do_fail = centre_score > rd_score;
        do_inc  = 1'b1;
      end
      ST_DONE: begin
        if (!(emit && m_tvalid && !m_tready)) begin
          do_drop = 1'b1;
          if (emit) begin
            load_out = 1'b1;
            drop_cnt = WLEN_W'(centre) + WLEN_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // With a full ring the oldest entry goes, and head + fill still addresses
  // the slot after the newest one.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_score[head + RING_W'(fill)] <= q_head.score;
      ring_index[head + RING_W'(fill)] <= frame_counter;
    end
    rd_score <= ring_score[raddr];
    rd_index <= ring_index[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      fill          <= '0;
      frame_counter <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (ring_we) begin
        fill          <= fill_after;
        frame_counter <= frame_counter + INDEX_W'(1);
        if (fill == WLEN_W'(MAX_WINDOW)) begin
          head <= head + RING_W'(1);
        end
      end
      if (do_drop) begin
        head <= head + RING_W'(drop_cnt);
        fill <= fill - drop_cnt;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      len <= len_now;
    end
    if (do_latch) begin
      centre_score <= rd_score;
      centre_index <= rd_index;
      is_min       <= 1'b1;
      idx          <= '0;
    end
    if (do_fail) begin
      is_min <= 1'b0;
    end
    if (do_inc) begin
      idx <= idx + WLEN_W'(1);
    end
    if (load_out) begin
      frame_index <= centre_index;
      frame_score <= centre_score;
    end
  end

endmodule
`default_nettype wire

/* src/still_frame_selector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// still_frame_selector
// Picks still frames out of a grey video stream by local minima of motion.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order while s_tready is high, with
// tlast on the last pixel of each frame. Each pixel does one read and one write
// of the previous frame store, a 2M x 8 single-port memory, and its absolute
// difference is added in the following cycle. A frame's score goes into a
// four-entry queue; the window logic behind it alternates ring reads with
// compares and ends its scan early when a lower entry is found. The pixel
// input stalls only while the queue holds four frame scores, or three and a
// frame end still in the pipeline. A selected frame appears on the master side
// as one transaction with its index and score. The store is not cleared after
// reset; the first frame after reset scores the maximum and is not compared.
// ----------------------------------------------------------------------------
module still_frame_selector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] pixel
  input  wire logic        s_tlast,   // last_in_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // [23:0] frame_index, [52:24] frame_score
);
  import ssel_pkg::*;

  logic [SCORE_W-1:0] threshold_sum;
  logic [WLEN_W-1:0]  window_length;
  logic               cfg_write;
  logic               reg_sel;
  ssel_score_t        score_push;
  ssel_score_t        q_head;
  ssel_q_status_t     q_status;
  logic               q_pop;
  logic [INDEX_W-1:0] frame_index;
  logic [SCORE_W-1:0] frame_score;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sum <= SCORE_W'(1048576);
      window_length <= WLEN_W'(5);
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_THRESHOLD: threshold_sum <= pwdata[SCORE_W-1:0];
        REG_WINDOW:    window_length <= pwdata[WLEN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD: prdata = 32'(threshold_sum);
      REG_WINDOW:    prdata = 32'(window_length);
      default:       prdata = '0;
    endcase
  end

  ssel_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .pixel         (s_tdata),
    .last_in_frame (s_tlast),
    .q_status      (q_status),
    .score_push    (score_push)
  );

  ssel_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (score_push),
    .pop    (q_pop),
    .head   (q_head),
    .status (q_status)
  );

  ssel_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .threshold_sum (threshold_sum),
    .window_length (window_length),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .frame_index   (frame_index),
    .frame_score   (frame_score)
  );

  assign m_tdata = {3'b000, frame_score, frame_index};

endmodule
`default_nettype wire

/* dv/still_frame_selector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// still_frame_selector_tb
// Self-checking testbench for the still frame selector.
// ----------------------------------------------------------------------------
// Grey frames of up to sixteen pixels are streamed into the slave side. The
// frames are nearly still copies of the previous frame, fully random frames,
// or flat black or white frames. A predictor tracks the previous frame, the
// motion score of each frame and the window of recent scores. It queues every
// frame that should be selected, and each master-side transaction is checked
// against the oldest queued selection. Threshold and window length change
// between phases while the block is idle. One phase holds the master side off
// long enough that the block must stall its pixel input.
// ----------------------------------------------------------------------------
module still_frame_selector_tb;
  import ssel_pkg::*;

  localparam int FRAME_MAX     = 16;
  localparam int ITEM_TARGET   = 1200;
  localparam int MAX_PHASES    = 100;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 600;

  typedef enum int {FR_STILL, FR_MOVING, FR_BLACK, FR_WHITE} frame_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [SCORE_W-1:0] score;
  } still_frame_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] pixel
  logic        s_tlast  = 1'b0; // last_in_frame
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // [23:0] frame_index, [52:24] frame_score

  still_frame_selector u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and check bookkeeping.
  pixel_item_t  pixel_backlog[$];
  still_frame_t expected_stills[$];
  logic [7:0]   gen_frame [FRAME_MAX];
  int unsigned  pixels_queued  = 0;
  int unsigned  pixels_taken   = 0;
  int unsigned  error_count    = 0;
  bit           calm           = 1'b0;
  bit           hold_pending   = 1'b0;
  bit           hold_done      = 1'b0;
  int           hold_left      = 0;
  pixel_item_t  next_pixel;

  // Predictor state, mirroring the block's registers and stores.
  logic [SCORE_W-1:0] thr_cfg   = 29'd1048576;
  logic [WLEN_W-1:0]  wlen_cfg  = 4'd5;
  logic [7:0]         prev_pix [int];
  bit                 have_prev = 1'b0;
  int unsigned        pix_pos   = 0;
  int unsigned        motion_sum = 0;
  logic [SCORE_W-1:0] win_score[$];
  logic [INDEX_W-1:0] win_index[$];
  logic [INDEX_W-1:0] frame_no  = '0;

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 7);
  endfunction

  task automatic drop_oldest();
    void'(win_score.pop_front());
    void'(win_index.pop_front());
  endtask

  task automatic track_pixel(input logic [7:0] pix, input logic last);
    int unsigned        diff;
    int unsigned        len;
    int unsigned        mid;
    logic [SCORE_W-1:0] score;
    bit                 lowest;
    if (pix_pos < MAX_FRAME_PIXELS) begin
      if (have_prev) begin
        diff = (prev_pix[pix_pos] > pix) ? prev_pix[pix_pos] - pix : pix - prev_pix[pix_pos];
        motion_sum = motion_sum + diff;
        if (motion_sum > SCORE_MAX) motion_sum = SCORE_MAX;
      end
      prev_pix[pix_pos] = pix;
      pix_pos++;
    end
    if (!last) return;

    // The very first frame has nothing to compare with and scores the maximum.
    score = have_prev ? motion_sum[SCORE_W-1:0] : SCORE_MAX;
    have_prev  = 1'b1;
    pix_pos    = 0;
    motion_sum = 0;
    if (win_score.size() >= MAX_WINDOW) drop_oldest();
    win_score.push_back(score);
    win_index.push_back(frame_no);
    frame_no++;

    len = (wlen_cfg == 0) ? 1 : wlen_cfg;
    if (win_score.size() >= len) begin
      mid = len / 2;
      lowest = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (i != mid && win_score[mid] > win_score[i]) lowest = 1'b0;
      end
      if (lowest && win_score[mid] < thr_cfg) begin
        expected_stills.push_back('{win_index[mid], win_score[mid]});
        repeat (mid) drop_oldest();
      end
      drop_oldest();
    end
  endtask

  // Pixel driver: presents the backlog and feeds the predictor on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_pixel(s_tdata, s_tlast);
        pixels_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_backlog.size() != 0 && !idle_roll()) begin
          next_pixel = pixel_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_pixel.pix;
          s_tlast  <= next_pixel.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_stills.size() == 0) begin
          $error("unexpected still frame: index %0d score %0d", m_tdata[23:0], m_tdata[52:24]);
          error_count++;
        end else begin
          automatic still_frame_t exp_still = expected_stills.pop_front();
          if (m_tdata[23:0] !== exp_still.index) begin
            $error("frame_index: expected %0d, got %0d", exp_still.index, m_tdata[23:0]);
            error_count++;
          end
          if (m_tdata[52:24] !== exp_still.score) begin
            $error("frame_score: expected %0d, got %0d", exp_still.score, m_tdata[52:24]);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_pending && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_roll();
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_THRESHOLD) thr_cfg = value[SCORE_W-1:0];
    else wlen_cfg = value[WLEN_W-1:0];
    // Read the register straight back.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $error("register %0d readback: expected %0d, got %0d", idx, value, readback);
      error_count++;
    end
  endtask

  task automatic send_frame(input int size, input frame_kind_t kind);
    pixel_item_t item;
    for (int i = 0; i < size; i++) begin
      case (kind)
        FR_STILL:  item.pix = gen_frame[i] ^ {7'd0, ($urandom_range(0, 7) == 0)};
        FR_MOVING: item.pix = 8'($urandom_range(0, 255));
        FR_BLACK:  item.pix = 8'h00;
        default:   item.pix = 8'hFF;
      endcase
      item.last = (i == size - 1);
      gen_frame[i] = item.pix;
      pixel_backlog.push_back(item);
      pixels_queued++;
    end
  endtask

  // Lets the block go idle: all pixels taken, all selections seen, and time
  // for frames that select nothing to leave the window logic.
  task automatic drain();
    while (pixels_taken != pixels_queued || expected_stills.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          frames;
    int          size;
    frame_kind_t kind;
    logic [31:0] thr_pick;
    logic [31:0] wlen_pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the first frame sets the largest size any later frame
    // may have, so the pixel store is never read where it was not written.
    write_reg(REG_THRESHOLD, {3'd0, SCORE_MAX});
    write_reg(REG_WINDOW, 32'd1);
    send_frame(FRAME_MAX, FR_MOVING);
    send_frame(1, FR_WHITE);
    send_frame(2, FR_BLACK);
    send_frame(3, FR_STILL);
    send_frame(3, FR_WHITE);
    drain();

    phase = 0;
    while (pixels_queued < ITEM_TARGET && phase < MAX_PHASES) begin
      case (phase)
        0: begin
          wlen_pick = 32'd0;
          thr_pick  = 32'd0;
        end
        1: begin
          wlen_pick = 32'd15;
          thr_pick  = {3'd0, SCORE_MAX};
        end
        2: begin
          wlen_pick = 32'd2;
          thr_pick  = $urandom_range(0, 64);
        end
        3: begin
          wlen_pick = 32'd1;
          thr_pick  = {3'd0, SCORE_MAX};
        end
        default: begin
          wlen_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                   : 2 * $urandom_range(0, 3) + 1;
          case ($urandom_range(0, 4))
            0:       thr_pick = 32'd0;
            1:       thr_pick = {3'd0, SCORE_MAX};
            2:       thr_pick = $urandom_range(0, 64);
            3:       thr_pick = $urandom_range(0, 4096);
            default: thr_pick = $urandom() & {3'd0, SCORE_MAX};
          endcase
        end
      endcase
      write_reg(REG_WINDOW, wlen_pick);
      write_reg(REG_THRESHOLD, thr_pick);

      // Phase 3 stalls the master side so the score queue fills; phase 4 runs
      // both sides without gaps.
      calm = (phase == 3 || phase == 4);
      if (phase == 3) hold_pending = 1'b1;
      frames = $urandom_range(10, 30);
      for (int f = 0; f < frames; f++) begin
        if (phase == 3) size = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) size = FRAME_MAX;
        else size = $urandom_range(1, FRAME_MAX);
        kind = ($urandom_range(0, 9) < 7) ? FR_STILL : frame_kind_t'($urandom_range(1, 3));
        send_frame(size, kind);
      end
      drain();
      calm = 1'b0;
      phase++;
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
